FILE: rtl/doubly_linked_list_manager_defines.svh
// Assertion macros for the linked list manager
`ifndef DOUBLY_LINKED_LIST_MANAGER_DEFINES_SVH
`define DOUBLY_LINKED_LIST_MANAGER_DEFINES_SVH
`ifndef ASSERT_OFF
`define DLL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DLL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DLL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DLL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/dll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_pkg
// Shared types and codes of the linked list manager.
// ----------------------------------------------------------------------------
package dll_pkg;
    // node pool size; handle and position fields below are sized for it
    localparam int NODES = 64;

    localparam logic [3:0] CMD_APPEND     = 4'd0;
    localparam logic [3:0] CMD_PREPEND    = 4'd1;
    localparam logic [3:0] CMD_DROP_BACK  = 4'd2;
    localparam logic [3:0] CMD_DROP_FRONT = 4'd3;
    localparam logic [3:0] CMD_READ       = 4'd4;
    localparam logic [3:0] CMD_WRITE      = 4'd5;
    localparam logic [3:0] CMD_INSERT     = 4'd6;
    localparam logic [3:0] CMD_ERASE      = 4'd7;
    localparam logic [3:0] CMD_CLEAR      = 4'd8;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_BADH  = 3'd4;

    localparam logic signed [31:0] EMPTY_VAL = -32'sd7;
    localparam logic signed [31:0] RANGE_VAL = -32'sd9;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] value;
        logic [5:0]         position;
        logic [6:0]         handle;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] data;
        logic [6:0]         result_handle;
        logic [6:0]         size;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [6:0]         first_handle;
    } t_out;
endpackage

FILE: rtl/doubly_linked_list_manager.sv
`timescale 1ns / 1ps
// Pushes, pops, insert and erase pass S_RD1, S_RD1W, the S_WR steps and the S_FV
// phases before S_DONE; read and write by position repeat S_RD1 and S_RD1W for each
// list step (one link read per step), then pass S_FV. Rejected commands, clear and
// ignored commands go straight to S_DONE; the strobe is registered from S_DONE.
// One item at a time: busy drops in the strobe cycle; results cannot be stalled.
// Reset (synchronous, active low) empties the list; node memories need no clearing.
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// Doubly linked list in a node pool held in value and link memories.
// ----------------------------------------------------------------------------
`include "doubly_linked_list_manager_defines.svh"
module doubly_linked_list_manager
    import dll_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_item
);
    localparam int AW = $clog2(NODES);
    localparam int HW = AW + 1;
    localparam logic [HW-1:0] END_H = HW'(NODES);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RD1   = 8'b00000010,  // issue first read
        S_RD1W  = 8'b00000100,  // wait data
        S_RD2   = 8'b00001000,  // second read
        S_RD2W  = 8'b00010000,
        S_WR    = 8'b00100000,  // link writes
        S_FV    = 8'b01000000,  // front/back value refresh
        S_DONE  = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    t_in    r_in, n_in;

    logic [HW-1:0] r_first, n_first, r_last, n_last, r_count, n_count;
    logic [HW-1:0] r_fresh, n_fresh, r_free, n_free;
    logic [NODES-1:0] r_live, n_live;
    logic signed [31:0] r_fval, n_fval, r_bval, n_bval;

    // per-command working registers
    logic [HW-1:0] r_h, n_h;        // target / new node
    logic [HW-1:0] r_at, n_at;      // insert point
    logic [HW-1:0] r_bef, n_bef;
    logic [HW-1:0] r_aft, n_aft;
    logic [HW-1:0] r_rh, n_rh;
    logic [2:0]    r_st, n_st;
    logic signed [31:0] r_data, n_data;
    logic [5:0]    r_idx, n_idx;
    logic [2:0]    r_wstep, n_wstep;
    logic          r_ins, n_ins;    // link or unlink
    logic          r_walk, n_walk;
    logic          r_fvph, n_fvph;
    logic          r_strobe;
    t_out          r_out, n_out;

    // memories
    logic          val_we, nx_we, pv_we;
    logic [AW-1:0] val_wa, nx_wa, pv_wa, val_ra, nx_ra, pv_ra;
    logic [31:0]   val_wd, val_rd;
    logic [HW-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

    dll_ram #(.WIDTH(32), .DEPTH(NODES)) u_val (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_wa), .i_wdata(val_wd),
        .i_raddr(val_ra), .o_rdata(val_rd));
    dll_ram #(.WIDTH(HW), .DEPTH(NODES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd));
    dll_ram #(.WIDTH(HW), .DEPTH(NODES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd));

    function automatic logic live_of(input logic [NODES-1:0] lv, input logic [HW-1:0] h);
        logic r;
        r = 1'b0;
        if (h < END_H) begin
            r = lv[h[AW-1:0]];
        end
        return r;
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_item   = r_out;

    always_comb begin
        n_state = r_state; n_in = r_in;
        n_first = r_first; n_last = r_last; n_count = r_count;
        n_fresh = r_fresh; n_free = r_free; n_live = r_live;
        n_fval = r_fval;
        n_h = r_h; n_at = r_at; n_bef = r_bef; n_aft = r_aft; n_rh = r_rh;
        n_st = r_st; n_data = r_data; n_idx = r_idx; n_wstep = r_wstep;
        n_ins = r_ins; n_walk = r_walk; n_fvph = r_fvph;
        val_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        val_wa = '0; nx_wa = '0; pv_wa = '0;
        val_wd = '0; nx_wd = '0; pv_wd = '0;
        val_ra = '0; nx_ra = '0; pv_ra = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in = i_item;
                    n_st = ST_OK; n_data = '0; n_rh = END_H;
                    n_idx = '0; n_walk = 1'b0; n_fvph = 1'b0;
                    n_state = S_DONE;
                    case (i_item.command)
                        CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
                            if (i_item.command == CMD_INSERT && i_item.handle != END_H
                                && !live_of(r_live, HW'(i_item.handle))) begin
                                n_st = ST_BADH;
                            end else if (r_count >= END_H) begin
                                n_st = ST_FULL;
                            end else begin
                                n_ins = 1'b1;
                                n_at = (i_item.command == CMD_APPEND) ? END_H :
                                       (i_item.command == CMD_PREPEND) ? r_first :
                                       HW'(i_item.handle);
                                if (r_free < END_H) begin
                                    n_h = r_free;
                                end else begin
                                    n_h = r_fresh;
                                    n_fresh = r_fresh + 1'b1;
                                end
                                n_state = S_RD1;
                            end
                        end
                        CMD_DROP_BACK, CMD_DROP_FRONT, CMD_ERASE: begin
                            n_h = (i_item.command == CMD_DROP_BACK) ? r_last :
                                  (i_item.command == CMD_DROP_FRONT) ? r_first :
                                  HW'(i_item.handle);
                            if (!live_of(r_live, n_h) || r_count == '0) begin
                                n_st = (i_item.command == CMD_ERASE) ? ST_BADH : ST_EMPTY;
                            end else begin
                                n_ins = 1'b0;
                                n_state = S_RD1;
                            end
                        end
                        CMD_READ, CMD_WRITE: begin
                            if (HW'(i_item.position) >= r_count) begin
                                n_st = ST_RANGE; n_data = RANGE_VAL;
                            end else begin
                                n_walk = 1'b1;
                                n_h = r_first;
                                n_state = S_RD1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_first = END_H; n_last = END_H; n_count = '0;
                            n_fresh = '0; n_free = END_H; n_live = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD1: begin
                // walk: read next of r_h; insert: read prev of at and next of
                // new node (free list); erase: read both links of r_h
                nx_ra = r_h[AW-1:0];
                pv_ra = r_walk ? r_h[AW-1:0] : (r_ins ? r_at[AW-1:0] : r_h[AW-1:0]);
                val_ra = r_h[AW-1:0];
                n_state = S_RD1W;
            end
            S_RD1W: begin
                n_state = S_WR;
                n_wstep = '0;
                if (r_walk) begin
                    if (r_idx == r_in.position) begin
                        n_rh = r_h;
                        if (r_in.command == CMD_READ) begin
                            n_data = val_rd;
                        end else begin
                            val_we = 1'b1; val_wa = r_h[AW-1:0]; val_wd = r_in.value;
                        end
                        n_fvph = 1'b0;
                        n_state = S_FV;
                    end else begin
                        n_h = nx_rd;
                        n_idx = r_idx + 1'b1;
                        n_state = S_RD1;
                    end
                end else if (r_ins) begin
                    n_bef = (r_at < END_H) ? pv_rd : r_last;
                    if (r_free < END_H && r_h == r_free) begin
                        n_free = nx_rd;
                    end
                end else begin
                    n_bef = pv_rd;
                    n_aft = nx_rd;
                end
            end
            S_WR: begin
                // two write steps, one entry per memory each
                n_wstep = r_wstep + 1'b1;
                if (r_ins) begin
                    if (r_wstep == 3'd0) begin
                        val_we = 1'b1; val_wa = r_h[AW-1:0]; val_wd = r_in.value;
                        pv_we = 1'b1; pv_wa = r_h[AW-1:0]; pv_wd = r_bef;
                        nx_we = 1'b1; nx_wa = r_h[AW-1:0]; nx_wd = r_at;
                    end else begin
                        if (r_bef < END_H) begin
                            nx_we = 1'b1; nx_wa = r_bef[AW-1:0]; nx_wd = r_h;
                        end else begin
                            n_first = r_h;
                        end
                        if (r_at < END_H) begin
                            pv_we = 1'b1; pv_wa = r_at[AW-1:0]; pv_wd = r_h;
                        end else begin
                            n_last = r_h;
                        end
                        n_live[r_h[AW-1:0]] = 1'b1;
                        n_count = r_count + 1'b1;
                        n_rh = r_h;
                        n_fvph = 1'b0;
                        n_state = S_FV;
                    end
                end else begin
                    if (r_wstep == 3'd0) begin
                        if (r_bef < END_H) begin
                            nx_we = 1'b1; nx_wa = r_bef[AW-1:0]; nx_wd = r_aft;
                        end else begin
                            n_first = r_aft;
                        end
                        if (r_aft < END_H) begin
                            pv_we = 1'b1; pv_wa = r_aft[AW-1:0]; pv_wd = r_bef;
                        end else begin
                            n_last = r_bef;
                        end
                    end else begin
                        nx_we = 1'b1; nx_wa = r_h[AW-1:0]; nx_wd = r_free;
                        n_free = r_h;
                        n_live[r_h[AW-1:0]] = 1'b0;
                        n_count = r_count - 1'b1;
                        n_rh = (r_in.command == CMD_DROP_BACK) ? END_H : r_aft;
                        n_fvph = 1'b0;
                        n_state = S_FV;
                    end
                end
            end
            S_FV: begin
                // read front value, then back value
                if (!r_fvph) begin
                    val_ra = r_first[AW-1:0];
                    n_fvph = 1'b1;
                end else begin
                    val_ra = r_last[AW-1:0];
                    n_fval = val_rd;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // back value lands the cycle after S_FV ends
    logic r_bcap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= END_H; r_last <= END_H; r_count <= '0;
            r_fresh <= '0; r_free <= END_H; r_live <= '0;
            r_strobe <= 1'b0; r_bcap <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first; r_last <= n_last; r_count <= n_count;
            r_fresh <= n_fresh; r_free <= n_free; r_live <= n_live;
            r_bcap <= (r_state == S_FV) && r_fvph;
            r_strobe <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in; r_h <= n_h; r_at <= n_at; r_bef <= n_bef; r_aft <= n_aft;
        r_rh <= n_rh; r_st <= n_st; r_data <= n_data; r_idx <= n_idx;
        r_wstep <= n_wstep; r_ins <= n_ins; r_walk <= n_walk; r_fvph <= n_fvph;
        r_fval <= n_fval;
        r_bval <= r_bcap ? val_rd : n_bval;
        r_out <= n_out;
    end

    always_comb begin
        n_bval = r_bval;
        n_out = r_out;
        if (r_state == S_DONE) begin
            n_out.status = r_st;
            n_out.data = r_data;
            n_out.result_handle = 7'(r_rh);
            n_out.size = 7'(r_count);
            if (r_count != '0) begin
                n_out.front_value = r_fval;
                n_out.back_value = r_bcap ? val_rd : r_bval;
                n_out.first_handle = 7'(r_first);
            end else begin
                n_out.front_value = EMPTY_VAL;
                n_out.back_value = EMPTY_VAL;
                n_out.first_handle = 7'(END_H);
            end
        end
    end

    `DLL_ASSERT_NXT(a_strobe_after_done, i_clk, i_rst_n, r_state == S_DONE, o_strobe)
    `DLL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= END_H)
    `DLL_ASSERT_IMP(a_empty_ends, i_clk, i_rst_n, r_count == '0 && r_state == S_IDLE,
        r_first == END_H && r_last == END_H)
endmodule

FILE: rtl/dll_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_ram
// Generic simple dual-port RAM (separate write and read addresses), one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
